// ===== rtl/fbdb_pkg.sv =====
// ----------------------------------------------------------------------------
// fbdb_pkg
// Shared constants, operation codes and color helper functions for the
// RGB565 frame store with fill, pixel write, blended write and readout.
// ----------------------------------------------------------------------------
`default_nettype none

package fbdb_pkg;

  // default frame geometry
  localparam int DEF_FRAME_WIDTH  = 128;
  localparam int DEF_FRAME_HEIGHT = 160;

  // drawing operation codes
  localparam logic [1:0] OP_FILL  = 2'd0;
  localparam logic [1:0] OP_PIXEL = 2'd1;
  localparam logic [1:0] OP_BLEND = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  // alpha value that means an opaque write
  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  // lane form 00000gggggg00000rrrrr000000bbbbb
  localparam logic [31:0] LANE_MASK = 32'h07E0_F81F;

  // exchange the two bytes of a word
  function automatic logic [15:0] swap16(input logic [15:0] v);
    swap16 = {v[7:0], v[15:8]};
  endfunction

  // spread an RGB565 color into the green-red-blue lane form
  function automatic logic [31:0] spread(input logic [15:0] c);
    spread = {c, c} & LANE_MASK;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rgb565_framebuffer_draw_blend.sv =====
// ----------------------------------------------------------------------------
// rgb565_framebuffer_draw_blend
// Frame store of byte-swapped RGB565 words driven by drawing commands.
// ----------------------------------------------------------------------------
// One command is taken at a time over a single-port frame memory. A pixel
// write or an opaque blend goes through the write state; an out-of-frame
// command goes straight to done. A read goes through read and read-data,
// a blended write through read, registered multiply, write back, result.
// A rectangle fill writes one pixel per cycle. The memory port is the
// limit: every access, fill, read or blend write, goes through it one word
// per cycle. No clearing pass exists after reset: pixels are undefined
// until drawn, and the changed flag starts at zero. in_ready is high only
// while no command is in progress; a finished result waits in the output
// register, and a later command waits in done until that result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb565_framebuffer_draw_blend
  import fbdb_pkg::*;
#(
  parameter int FRAME_WIDTH  = DEF_FRAME_WIDTH,
  parameter int FRAME_HEIGHT = DEF_FRAME_HEIGHT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  operation,
  input  wire logic [15:0] colour,
  input  wire logic [7:0]  alpha,
  input  wire logic [7:0]  x_pos,
  input  wire logic [7:0]  y_pos,
  input  wire logic [8:0]  x_len,
  input  wire logic [8:0]  y_len,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [15:0] pixel_word,
  output logic             in_range,
  output logic             changed
);

  localparam int DEPTH  = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [8:0]        WIDTH_V  = 9'(FRAME_WIDTH);
  localparam logic [8:0]        HEIGHT_V = 9'(FRAME_HEIGHT);
  localparam logic [ADDR_W-1:0] ROW_STEP = ADDR_W'(FRAME_WIDTH);

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_FILL = 3'd1;
  localparam logic [2:0] ST_PIX  = 3'd2;
  localparam logic [2:0] ST_RD   = 3'd3;
  localparam logic [2:0] ST_RDD  = 3'd4;
  localparam logic [2:0] ST_WR   = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  logic [2:0]        state;
  logic [1:0]        op_q;
  logic [15:0]       colour_q;
  logic [7:0]        alpha_q;
  logic              inside_q;
  logic [7:0]        x_q;
  logic [8:0]        xe_q;
  logic [8:0]        ye_q;
  logic [7:0]        col;
  logic [7:0]        row;
  logic [ADDR_W-1:0] row_base;
  logic [ADDR_W-1:0] pix_addr_q;
  logic [15:0]       word_q;
  logic              changed_flag;

  logic              accept;
  logic              inside_in;
  logic [16:0]       row_off_in;
  logic [16:0]       pix_off_in;
  logic [9:0]        x_sum;
  logic [9:0]        y_sum;
  logic [8:0]        xe_in;
  logic [8:0]        ye_in;
  logic [8:0]        col_inc;
  logic [8:0]        row_inc;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_addr;
  logic [15:0]       mem_wdata;
  logic [15:0]       mem_rdata;
  logic [15:0]       blend_word;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // range check, addresses and clipped rectangle ends of the incoming command
  always_comb begin
    inside_in  = ({1'b0, x_pos} < WIDTH_V) && ({1'b0, y_pos} < HEIGHT_V);
    row_off_in = {9'd0, y_pos} * {8'd0, WIDTH_V};
    pix_off_in = row_off_in + {9'd0, x_pos};
    x_sum      = {2'd0, x_pos} + {1'b0, x_len};
    y_sum      = {2'd0, y_pos} + {1'b0, y_len};
    xe_in      = (x_sum > {1'b0, WIDTH_V})  ? WIDTH_V  : x_sum[8:0];
    ye_in      = (y_sum > {1'b0, HEIGHT_V}) ? HEIGHT_V : y_sum[8:0];
  end

  // fill walk increments
  assign col_inc = {1'b0, col} + 9'd1;
  assign row_inc = {1'b0, row} + 9'd1;

  // memory port select
  always_comb begin
    mem_we    = (state == ST_FILL) || (state == ST_PIX) || (state == ST_WR);
    mem_addr  = (state == ST_FILL) ? (row_base + ADDR_W'(col)) : pix_addr_q;
    mem_wdata = (state == ST_WR) ? blend_word : swap16(colour_q);
  end

  // command sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      changed_flag <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if ((state == ST_DONE) && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (operation)
              OP_FILL: begin
                changed_flag <= 1'b1;
                if (({1'b0, x_pos} >= xe_in) || ({1'b0, y_pos} >= ye_in)) begin
                  state <= ST_DONE;
                end else begin
                  state <= ST_FILL;
                end
              end
              OP_PIXEL: begin
                if (inside_in) begin
                  changed_flag <= 1'b1;
                  state        <= ST_PIX;
                end else begin
                  state <= ST_DONE;
                end
              end
              OP_BLEND: begin
                if (inside_in) begin
                  changed_flag <= 1'b1;
                  state        <= (alpha == ALPHA_OPAQUE) ? ST_PIX : ST_RD;
                end else begin
                  state <= ST_DONE;
                end
              end
              default: begin
                state <= inside_in ? ST_RD : ST_DONE;
              end
            endcase
          end
        end
        ST_FILL: begin
          if ((col_inc >= xe_q) && (row_inc >= ye_q)) begin
            state <= ST_DONE;
          end
        end
        ST_PIX: begin
          state <= ST_DONE;
        end
        ST_RD: begin
          state <= ST_RDD;
        end
        ST_RDD: begin
          state <= (op_q == OP_READ) ? ST_DONE : ST_WR;
        end
        ST_WR: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid || out_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // command fields and walk registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q       <= operation;
      colour_q   <= colour;
      alpha_q    <= alpha;
      inside_q   <= inside_in;
      x_q        <= x_pos;
      xe_q       <= xe_in;
      ye_q       <= ye_in;
      col        <= x_pos;
      row        <= y_pos;
      row_base   <= row_off_in[ADDR_W-1:0];
      pix_addr_q <= pix_off_in[ADDR_W-1:0];
      word_q     <= 16'd0;
    end else begin
      if ((state == ST_RDD) && (op_q == OP_READ)) begin
        word_q <= mem_rdata;
      end
      // step across the row, then down to the next one
      if (state == ST_FILL) begin
        if (col_inc < xe_q) begin
          col <= col_inc[7:0];
        end else begin
          col <= x_q;
          if (row_inc < ye_q) begin
            row      <= row_inc[7:0];
            row_base <= row_base + ROW_STEP;
          end
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && (!out_valid || out_ready)) begin
      pixel_word <= word_q;
      in_range   <= inside_q;
      changed    <= changed_flag;
    end
  end

  fbdb_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  fbdb_blend u_blend (
    .clk    (clk),
    .load   (state == ST_RDD),
    .stored (mem_rdata),
    .colour (colour_q),
    .alpha  (alpha_q),
    .result (blend_word)
  );

endmodule

`default_nettype wire

// ===== rtl/fbdb_store.sv =====
// ----------------------------------------------------------------------------
// fbdb_store
// Single-port frame memory: one write or one read per cycle, read data
// registered. Contents are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module fbdb_store #(
  parameter int DEPTH  = 20480,
  parameter int ADDR_W = 15
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] addr,
  input  wire logic [15:0]       wdata,
  output logic      [15:0]       rdata
);

  logic [15:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// ===== rtl/fbdb_blend.sv =====
// ----------------------------------------------------------------------------
// fbdb_blend
// Alpha blend unit: spreads stored and new color into lane form, registers
// the weighted difference, then adds, folds and byte-swaps the result.
// ----------------------------------------------------------------------------
`default_nettype none

module fbdb_blend
  import fbdb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        load,
  input  wire logic [15:0] stored,
  input  wire logic [15:0] colour,
  input  wire logic [7:0]  alpha,
  output logic      [15:0] result
);

  logic [31:0] bg;
  logic [31:0] fg;
  logic [31:0] diff;
  logic [5:0]  weight;
  logic [8:0]  alpha_rnd;
  logic [31:0] prod;
  logic [31:0] bg_q;
  logic [31:0] prod_q;
  logic [31:0] sum;
  logic [31:0] folded;

  // lane spread and weighted difference, weight out of 32
  always_comb begin
    bg        = spread(swap16(stored));
    fg        = spread(colour);
    alpha_rnd = {1'b0, alpha} + 9'd4;
    weight    = alpha_rnd[8:3];
    diff      = fg - bg;
    prod      = diff * {26'd0, weight};
  end

  // product register
  always_ff @(posedge clk) begin
    if (load) begin
      bg_q   <= bg;
      prod_q <= prod;
    end
  end

  // add back, fold lanes, return to stored byte order
  always_comb begin
    sum    = bg_q + ((prod_q >> 5) & LANE_MASK);
    folded = sum | (sum >> 16);
    result = swap16(folded[15:0]);
  end

endmodule

`default_nettype wire
